// ===== rtl/sha256_message_padder_defines.svh =====
// Assertion macros used by the padder back end.
`ifndef SHA256_MESSAGE_PADDER_DEFINES_SVH
`define SHA256_MESSAGE_PADDER_DEFINES_SVH

// Check a property on a given clock, disabled while the active-low reset is low.
`define S256PAD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("s256pad assertion failed");

// Same check on the standard clk_i / rst_ni pair.
`define S256PAD_ASSERT_STD(label, prop) \
  `S256PAD_ASSERT(label, clk_i, rst_ni, prop)

`endif

// ===== rtl/s256pad_pkg.sv =====
// Types and constants of the SHA-256 message padder.
package s256pad_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned LenW      = 64;
  localparam int unsigned MsgCntW   = 61;
  localparam int unsigned ByteCntW  = 2;
  localparam int unsigned WordCntW  = 4;

  // Word slot where the 64-bit length starts, and last slot of a block.
  localparam logic [WordCntW-1:0] LenHiSlot = 4'd14;
  localparam logic [WordCntW-1:0] LastSlot  = 4'd15;

  localparam logic [ByteW-1:0] PadByte = 8'h80;

  // Command codes.
  localparam logic CmdAppend = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // Queue between front and back end.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One queue entry: a full data word, or a finish job that carries the
  // partial word, its byte count and the message byte count.
  typedef struct packed {
    logic                 is_finish;
    logic [WordW-1:0]     word;
    logic [ByteCntW-1:0]  nbytes;
    logic [MsgCntW-1:0]   msg_bytes;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ZERO   = 5'b00010,
    ST_LEN_HI = 5'b00100,
    ST_LEN_LO = 5'b01000,
    ST_SPARE  = 5'b10000
  } back_state_e;

  // Close a partial word with the pad byte, zero fill the rest.
  function automatic logic [WordW-1:0] pad_word(input logic [WordW-1:0]    pw,
                                                input logic [ByteCntW-1:0] nb);
    logic [WordW-1:0] w;
    case (nb)
      2'd0:    w = {PadByte, 24'h0};
      2'd1:    w = {pw[7:0], PadByte, 16'h0};
      2'd2:    w = {pw[15:0], PadByte, 8'h0};
      default: w = {pw[23:0], PadByte};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/s256pad_if.sv =====
// Request and result channel interfaces of the padder.
interface s256pad_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [s256pad_pkg::ByteW-1:0] message_byte;

  modport source (output valid, output command, output message_byte, input ready);
  modport sink   (input valid, input command, input message_byte, output ready);
endinterface

interface s256pad_res_if;
  logic                          valid;
  logic                          ready;
  logic [s256pad_pkg::WordW-1:0] word;
  logic                          block_end;
  logic                          last;

  modport source (output valid, output word, output block_end, output last, input ready);
  modport sink   (input valid, input word, input block_end, input last, output ready);
endinterface

// ===== rtl/s256pad_front.sv =====
// Front end: accepts requests, packs bytes and queues words and finish jobs.
module s256pad_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  s256pad_req_if.sink          req_i,
  input  logic                 full_i,
  output logic                 push_o,
  output s256pad_pkg::entry_t  entry_o
);

  logic [s256pad_pkg::WordW-1:0]    pw_q, pw_d;
  logic [s256pad_pkg::ByteCntW-1:0] nb_q, nb_d;
  logic [s256pad_pkg::MsgCntW-1:0]  mb_q, mb_d;
  logic                             accept;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && !full_i;

  always_comb begin
    pw_d              = pw_q;
    nb_d              = nb_q;
    mb_d              = mb_q;
    push_o            = 1'b0;
    entry_o.is_finish = 1'b0;
    entry_o.word      = {pw_q[s256pad_pkg::WordW-s256pad_pkg::ByteW-1:0], req_i.message_byte};
    entry_o.nbytes    = nb_q;
    entry_o.msg_bytes = mb_q;
    if (accept) begin
      if (req_i.command == s256pad_pkg::CmdFinish) begin
        // Hand the open word and the count to the back end, start afresh.
        push_o            = 1'b1;
        entry_o.is_finish = 1'b1;
        entry_o.word      = pw_q;
        pw_d              = '0;
        nb_d              = '0;
        mb_d              = '0;
      end else begin
        pw_d   = entry_o.word;
        nb_d   = nb_q + 2'd1;
        mb_d   = mb_q + 61'd1;
        push_o = (nb_q == 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= '0;
      nb_q <= '0;
      mb_q <= '0;
    end else begin
      pw_q <= pw_d;
      nb_q <= nb_d;
      mb_q <= mb_d;
    end
  end

endmodule

// ===== rtl/s256pad_fifo.sv =====
// Short queue of entries between front and back end.
module s256pad_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  s256pad_pkg::entry_t  entry_i,
  input  logic                 pop_i,
  output s256pad_pkg::entry_t  entry_o,
  output logic                 full_o,
  output logic                 empty_o
);

  s256pad_pkg::entry_t              mem_q [s256pad_pkg::QDepth];
  logic [s256pad_pkg::QPtrW-1:0]    wr_q, rd_q;
  logic [s256pad_pkg::QCntW-1:0]    cnt_q;
  logic                             do_push, do_pop;

  localparam logic [s256pad_pkg::QPtrW-1:0] PtrMax =
    s256pad_pkg::QPtrW'(s256pad_pkg::QDepth - 1);

  assign full_o  = (cnt_q == s256pad_pkg::QCntW'(s256pad_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/s256pad_back.sv =====
// Back end: emits queued words and sequences the padding of a finish job.
`include "sha256_message_padder_defines.svh"

module s256pad_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s256pad_pkg::entry_t  entry_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  s256pad_res_if.source        res_o
);

  s256pad_pkg::back_state_e         state_q, state_d;
  logic [s256pad_pkg::WordCntW-1:0] wib_q, wib_d, wib_inc;
  logic [s256pad_pkg::LenW-1:0]     len_q, len_d;
  logic                             vld_q, vld_d;
  logic [s256pad_pkg::WordW-1:0]    word_q, word_d;
  logic                             bend_q, bend_d;
  logic                             last_q, last_d;
  logic                             load;

  assign res_o.valid     = vld_q;
  assign res_o.word      = word_q;
  assign res_o.block_end = bend_q;
  assign res_o.last      = last_q;

  assign load    = !vld_q || res_o.ready;
  assign wib_inc = wib_q + 4'd1;

  always_comb begin
    state_d = state_q;
    wib_d   = wib_q;
    len_d   = len_q;
    vld_d   = vld_q && !res_o.ready;
    word_d  = word_q;
    bend_d  = bend_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      unique case (state_q)
        s256pad_pkg::ST_IDLE: begin
          if (!empty_i) begin
            pop_o  = 1'b1;
            vld_d  = 1'b1;
            bend_d = (wib_q == s256pad_pkg::LastSlot);
            last_d = 1'b0;
            wib_d  = wib_inc;
            if (entry_i.is_finish) begin
              word_d  = s256pad_pkg::pad_word(entry_i.word, entry_i.nbytes);
              len_d   = {entry_i.msg_bytes, 3'b000};
              state_d = (wib_inc == s256pad_pkg::LenHiSlot) ? s256pad_pkg::ST_LEN_HI
                                                             : s256pad_pkg::ST_ZERO;
            end else begin
              word_d = entry_i.word;
            end
          end
        end
        s256pad_pkg::ST_ZERO: begin
          vld_d  = 1'b1;
          word_d = '0;
          bend_d = (wib_q == s256pad_pkg::LastSlot);
          last_d = 1'b0;
          wib_d  = wib_inc;
          if (wib_inc == s256pad_pkg::LenHiSlot) begin
            state_d = s256pad_pkg::ST_LEN_HI;
          end
        end
        s256pad_pkg::ST_LEN_HI: begin
          vld_d   = 1'b1;
          word_d  = len_q[s256pad_pkg::LenW-1:s256pad_pkg::WordW];
          bend_d  = 1'b0;
          last_d  = 1'b0;
          wib_d   = wib_inc;
          state_d = s256pad_pkg::ST_LEN_LO;
        end
        s256pad_pkg::ST_LEN_LO: begin
          vld_d   = 1'b1;
          word_d  = len_q[s256pad_pkg::WordW-1:0];
          bend_d  = 1'b1;
          last_d  = 1'b1;
          wib_d   = '0;
          state_d = s256pad_pkg::ST_IDLE;
        end
        default: begin
          state_d = s256pad_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    bend_q <= bend_d;
    last_q <= last_d;
    len_q  <= len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= s256pad_pkg::ST_IDLE;
      wib_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wib_q   <= wib_d;
      vld_q   <= vld_d;
    end
  end

  `S256PAD_ASSERT_STD(a_last_ends_block, (vld_q && last_q) |-> bend_q)
  `S256PAD_ASSERT_STD(a_len_hi_slot, (state_q == s256pad_pkg::ST_LEN_HI) |-> (wib_q == s256pad_pkg::LenHiSlot))
  `S256PAD_ASSERT_STD(a_len_lo_slot, (state_q == s256pad_pkg::ST_LEN_LO) |-> (wib_q == s256pad_pkg::LastSlot))
  `S256PAD_ASSERT_STD(a_zero_not_len, (state_q == s256pad_pkg::ST_ZERO) |-> (wib_q != s256pad_pkg::LenHiSlot))

endmodule

// ===== rtl/sha256_message_padder.sv =====
// SHA-256 message padder: byte requests in, padded big-endian words out.
// Throughput: one request per cycle while the 4-entry queue has room; the back end
//   emits one word per cycle unless res_o stalls it.
// Path: a word enters the queue when its last request is accepted, then passes into
//   the registered res_o outputs, unless earlier work or res_o stalls hold it.
// Reset (rst_ni low, asynchronous) empties the queue and clears all counters.
module sha256_message_padder (
  input  logic          clk_i,
  input  logic          rst_ni,
  s256pad_req_if.sink   req_i,
  s256pad_res_if.source res_o
);

  // Front end -> queue.
  logic                push;
  s256pad_pkg::entry_t push_entry;
  logic                q_full;

  // Queue -> back end.
  logic                pop;
  s256pad_pkg::entry_t head_entry;
  logic                q_empty;

  // Front end: pack bytes, count the message, drop each full word or
  // finish job into the queue. Hold ready low only while the queue is full.
  s256pad_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .full_i  (q_full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Queue: decouple byte intake from the multi-word padding sequence.
  s256pad_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: track the word slot within the block, advance through pad,
  // zero fill and length words into the registered output.
  s256pad_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (q_empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ===== sim/sha256_message_padder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the SHA-256 message padder.
module sha256_message_padder_test;

  // One request as the driver presents it. A draining request is held back
  // until every word predicted so far has come out of the block.
  typedef struct {
    logic                          command;
    logic [s256pad_pkg::ByteW-1:0] data;
    bit                            drain;
  } pad_request_t;

  // One padded word as the block should emit it.
  typedef struct {
    logic [s256pad_pkg::WordW-1:0] word;
    logic                          block_end;
    logic                          last;
  } padded_word_t;

  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned TailCycles     = 20;
  localparam int unsigned RandomRequests = 252;
  localparam int unsigned IdlePercent    = 38;
  // Byte position within a block where the 64-bit length field begins.
  localparam logic [s256pad_pkg::WordCntW+s256pad_pkg::ByteCntW-1:0] LenStartByte = 6'd56;

  logic clk_i;
  logic rst_ni;

  s256pad_req_if req ();
  s256pad_res_if res ();

  sha256_message_padder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  pad_request_t requests_pending[$];
  pad_request_t on_wire;
  padded_word_t words_due[$];

  // Shadow of the padder state.
  logic [s256pad_pkg::WordW-1:0]    pack_word;
  logic [s256pad_pkg::ByteCntW-1:0] pack_bytes;
  logic [s256pad_pkg::MsgCntW-1:0]  msg_count;
  logic [s256pad_pkg::WordCntW-1:0] block_slot;

  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned issued;

  // Keep both sides busy every cycle during one stretch of the run.
  wire steady = (issued >= 120) && (issued < 180);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Pack one byte into the shadow word; emit the word once four bytes are in.
  task automatic pack_byte(input logic [s256pad_pkg::ByteW-1:0] b);
    padded_word_t w;
    pack_word  = {pack_word[s256pad_pkg::WordW-s256pad_pkg::ByteW-1:0], b};
    pack_bytes = pack_bytes + 1'b1;
    if (pack_bytes == '0) begin
      w.word      = pack_word;
      w.block_end = (block_slot == s256pad_pkg::LastSlot);
      w.last      = 1'b0;
      words_due.push_back(w);
      block_slot = block_slot + 1'b1;
      pack_word  = '0;
    end
  endtask

  // Advance the shadow state by one accepted request and queue the words it yields.
  task automatic absorb_request(input pad_request_t r);
    logic [s256pad_pkg::LenW-1:0] bit_len;
    if (r.command == s256pad_pkg::CmdAppend) begin
      msg_count = msg_count + 1'b1;
      pack_byte(r.data);
    end else begin
      // Length in bits, taken before the pad bytes touch the state.
      bit_len = {msg_count, 3'b000};
      pack_byte(s256pad_pkg::PadByte);
      while ({block_slot, pack_bytes} != LenStartByte)
        pack_byte('0);
      for (int i = s256pad_pkg::LenW / s256pad_pkg::ByteW - 1; i >= 0; i--)
        pack_byte(bit_len[i*s256pad_pkg::ByteW +: s256pad_pkg::ByteW]);
      // Flag the final word of the padded message, then clear for the next one.
      words_due[words_due.size()-1].last = 1'b1;
      pack_word  = '0;
      pack_bytes = '0;
      msg_count  = '0;
      block_slot = '0;
    end
  endtask

  task automatic push_request(input logic cmd, input logic [s256pad_pkg::ByteW-1:0] data,
                              input bit drain);
    pad_request_t r;
    r.command = cmd;
    r.data    = data;
    r.drain   = drain;
    requests_pending.push_back(r);
  endtask

  // Queue a message of random bytes and its finish; the drain flag lands on
  // its first request.
  task automatic queue_message(input int len, input bit drain);
    for (int i = 0; i < len; i++)
      push_request(s256pad_pkg::CmdAppend, s256pad_pkg::ByteW'($urandom_range(0, 255)),
                   drain && (i == 0));
    push_request(s256pad_pkg::CmdFinish, s256pad_pkg::ByteW'($urandom_range(0, 255)),
                 drain && (len == 0));
  endtask

  // Driver: predict on acceptance, then present the next request unless the
  // sender idles or a draining request waits for the block to empty.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        absorb_request(on_wire);
        issued <= issued + 1;
      end
      // Hold the request on the wire until it is taken.
      if (!req.valid || req.ready) begin
        if (requests_pending.size() != 0
            && !(requests_pending[0].drain && words_due.size() != 0)
            && (steady || $urandom_range(0, 99) >= IdlePercent)) begin
          on_wire = requests_pending.pop_front();
          req.valid        <= 1'b1;
          req.command      <= on_wire.command;
          req.message_byte <= on_wire.data;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest prediction, and
  // stall the result side at random.
  always @(posedge clk_i) begin
    padded_word_t want;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (words_due.size() == 0) begin
          $error("word %h arrived with no word expected", res.word);
          mismatches++;
        end else begin
          want = words_due.pop_front();
          if (res.word !== want.word) begin
            $error("word: expected %h, got %h", want.word, res.word);
            mismatches++;
          end
          if (res.block_end !== want.block_end) begin
            $error("block_end: expected %b, got %b", want.block_end, res.block_end);
            mismatches++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, res.last);
            mismatches++;
          end
        end
      end
      res.ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Watchdog: count cycles in which neither side moves a request or a word.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    bit timed_out;
    int directed_count;
    int len;
    int room;
    timed_out        = 1'b0;
    req.valid        = 1'b0;
    req.command      = s256pad_pkg::CmdAppend;
    req.message_byte = '0;
    res.ready        = 1'b0;
    rst_ni           = 1'b0;
    stall_cycles     = 0;
    mismatches       = 0;
    issued           = 0;
    pack_word        = '0;
    pack_bytes       = '0;
    msg_count        = '0;
    block_slot       = '0;

    // Empty message: one block, pad byte first, zero length.
    push_request(s256pad_pkg::CmdFinish, 8'h00, 1'b0);
    // One all-ones byte; wait for the empty message to drain first.
    push_request(s256pad_pkg::CmdAppend, 8'hFF, 1'b1);
    push_request(s256pad_pkg::CmdFinish, 8'hFF, 1'b0);
    // Three bytes: pad byte closes the partial word.
    push_request(s256pad_pkg::CmdAppend, 8'h00, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'hFF, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'h80, 1'b0);
    push_request(s256pad_pkg::CmdFinish, 8'h00, 1'b0);
    // Exactly one word: pad byte opens a fresh word.
    push_request(s256pad_pkg::CmdAppend, 8'hFF, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'hFF, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'hFF, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'hFF, 1'b0);
    push_request(s256pad_pkg::CmdFinish, 8'h55, 1'b0);
    // Five bytes: one full word, one byte left over.
    push_request(s256pad_pkg::CmdAppend, 8'hAA, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'h55, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'h00, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'hFF, 1'b0);
    push_request(s256pad_pkg::CmdAppend, 8'h7F, 1'b0);
    push_request(s256pad_pkg::CmdFinish, 8'hAA, 1'b0);
    directed_count = requests_pending.size();

    // Random messages: mostly short, some right at the 55/56-byte boundary where
    // the length spills into a second block, and a few long multi-block ones.
    // Trim the last message so the run ends on the request budget.
    for (int m = 0; requests_pending.size() < directed_count + RandomRequests; m++) begin
      room = directed_count + RandomRequests - requests_pending.size();
      if ($urandom_range(0, 3) == 0)
        len = 55 + $urandom_range(0, 1) + 64 * $urandom_range(0, 1);
      else if ($urandom_range(0, 4) == 0)
        len = $urandom_range(65, 130);
      else
        len = $urandom_range(0, 64);
      if (len > room - 1)
        len = room - 1;
      queue_message(len, (m % 8) == 2);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        while (requests_pending.size() != 0 || req.valid)
          @(posedge clk_i);
        while (words_due.size() != 0)
          @(posedge clk_i);
        // Give a stray extra word time to show up.
        repeat (TailCycles) @(posedge clk_i);
      end
      begin
        while (stall_cycles < StallLimit)
          @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out && mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
